[src/mmdh_pkg.sv]
`timescale 1ns / 1ps
package mmdh_pkg;

  localparam int unsigned NumStates = 27;

  typedef enum logic [NumStates-1:0] {
    S_IDLE   = 27'd1 << 0,
    S_START  = 27'd1 << 1,
    S_OLDD   = 27'd1 << 2,
    S_SETTLE = 27'd1 << 3,
    S_UP     = 27'd1 << 4,
    S_UPH    = 27'd1 << 5,
    S_UPV    = 27'd1 << 6,
    S_UPEND  = 27'd1 << 7,
    S_CHK    = 27'd1 << 8,
    S_CHH    = 27'd1 << 9,
    S_CHV    = 27'd1 << 10,
    S_SW0    = 27'd1 << 11,
    S_SW1    = 27'd1 << 12,
    S_SW2    = 27'd1 << 13,
    S_SW3    = 27'd1 << 14,
    S_SW4    = 27'd1 << 15,
    S_DN     = 27'd1 << 16,
    S_DCH    = 27'd1 << 17,
    S_DCV    = 27'd1 << 18,
    S_DSEL   = 27'd1 << 19,
    S_DNEND  = 27'd1 << 20,
    S_RES0   = 27'd1 << 21,
    S_RES1   = 27'd1 << 22,
    S_RES2   = 27'd1 << 23,
    S_RES3   = 27'd1 << 24,
    S_RES4   = 27'd1 << 25,
    S_OUT    = 27'd1 << 26
  } state_e;

  localparam logic SelLower = 1'b1;
  localparam logic SelUpper = 1'b0;

endpackage

[src/moving_median_double_heap_unit.sv]
`timescale 1ns / 1ps
// Channel | Direction | Handshake             | Payload
// input   | in        | in_valid_i/in_ready_o | sample_i
// output  | out       | out_valid_o/out_ready_i | median_doubled_o, median_valid_o
// config  | in        | window_len_we_i       | window_len_i
//
// One sample at a time. Each sample runs fixed work plus sift-up and sift-down levels,
// comparing up to HEAP_ARITY children per sift-down level, and may need a head check;
// a head swap adds the swap states and a second sift-down. The result register holds
// one finished transaction; the next sample is taken while it waits. Reset clears
// counts, window length (8) and oldest pointer; RAMs are not cleared.
module moving_median_double_heap_unit #(
  parameter int unsigned WINDOW_MAX  = 64,
  parameter int unsigned HEAP_ARITY  = 8,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          window_len_we_i,
  input  logic [6:0]                    window_len_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS:0]   median_doubled_o,
  output logic                          median_valid_o
);
  import mmdh_pkg::*;

  localparam int unsigned SB  = SAMPLE_BITS;
  localparam int unsigned SW  = $clog2(WINDOW_MAX);
  localparam int unsigned LW  = SW + 1;
  localparam int unsigned HD  = (WINDOW_MAX + 1) / 2;
  localparam int unsigned HPW = (HD > 1) ? $clog2(HD) : 1;
  localparam int unsigned HA  = HPW + 1;
  localparam int unsigned CW  = HPW + 1;
  localparam int unsigned FW  = HPW + 4;
  localparam int unsigned K   = HPW + 7;
  localparam int unsigned M   = ((1 << K) + HEAP_ARITY - 1) / HEAP_ARITY;
  localparam int unsigned WinReset = (8 < WINDOW_MAX) ? 8 : WINDOW_MAX;

  function automatic logic ahead(input logic is_max, input logic signed [SB-1:0] a,
                                 input logic signed [SB-1:0] b);
    return is_max ? (a > b) : (a < b);
  endfunction

  state_e state_q, state_d;
  logic signed [SB-1:0] v_q, v_d, bv_q, bv_d, lv_q, lv_d, lo_q, lo_d;
  logic [SW-1:0] slot_q, slot_d, bs_q, bs_d, ls_q, ls_d, us_q, us_d, oldest_q, oldest_d;
  logic sel_q, sel_d, moved_q, moved_d, swap2_q, swap2_d, valid_q, valid_d;
  logic [HPW-1:0] pos_q, pos_d, best_q, best_d;
  logic [FW-1:0] first_q, first_d, idx_q, idx_d;
  logic [CW-1:0] lc_q, lc_d, uc_q, uc_d;
  logic [LW-1:0] wlen_q, wlen_d;
  logic signed [SB:0] res_q, res_d, med_q, med_d;
  logic out_valid_q, out_valid_d, medv_q, medv_d;

  // child slot captured between heap read and value compare
  logic [SW-1:0] cand_q, cand_d;
  logic          cand_we;

  logic val_we, inl_we, pos_we, heap_we, inl_wdata, inl_rdata;
  logic [SW-1:0] val_waddr, val_raddr, inl_waddr, inl_raddr, pos_waddr, pos_raddr;
  logic [SW-1:0] heap_wdata, heap_rdata;
  logic signed [SB-1:0] val_wdata, val_rdata;
  logic [HPW-1:0] pos_wdata, pos_rdata;
  logic [HA-1:0] heap_waddr, heap_raddr;

  mmdh_ram #(.WIDTH(SB), .DEPTH(1 << SW)) u_val (
    .clk_i, .we_i(val_we), .waddr_i(val_waddr), .wdata_i(val_wdata),
    .raddr_i(val_raddr), .rdata_o(val_rdata));
  mmdh_ram #(.WIDTH(1), .DEPTH(1 << SW)) u_inl (
    .clk_i, .we_i(inl_we), .waddr_i(inl_waddr), .wdata_i(inl_wdata),
    .raddr_i(inl_raddr), .rdata_o(inl_rdata));
  mmdh_ram #(.WIDTH(HPW), .DEPTH(1 << SW)) u_pos (
    .clk_i, .we_i(pos_we), .waddr_i(pos_waddr), .wdata_i(pos_wdata),
    .raddr_i(pos_raddr), .rdata_o(pos_rdata));
  mmdh_ram #(.WIDTH(SW), .DEPTH(1 << HA)) u_heap (
    .clk_i, .we_i(heap_we), .waddr_i(heap_waddr), .wdata_i(heap_wdata),
    .raddr_i(heap_raddr), .rdata_o(heap_rdata));

  // parent = (pos - 1) / HEAP_ARITY by reciprocal multiply
  logic [HPW-1:0]   pm1, parent;
  logic [HPW+K-1:0] prod;
  assign pm1    = pos_q - HPW'(1);
  assign prod   = (HPW+K)'(pm1) * (HPW+K)'(M);
  assign parent = HPW'(prod >> K);

  logic [LW-1:0] total;
  logic [FW-1:0] first_w, cnt_w, lastp, last_w;
  logic [CW-1:0] other_cnt;
  logic [31:0]   cfg_ext;
  assign total     = LW'(lc_q) + LW'(uc_q);
  assign first_w   = FW'(pos_q) * FW'(HEAP_ARITY) + FW'(1);
  assign cnt_w     = FW'(sel_q ? lc_q : uc_q);
  assign lastp     = first_w + FW'(HEAP_ARITY);
  assign last_w    = (lastp > cnt_w) ? cnt_w : lastp;
  assign other_cnt = sel_q ? uc_q : lc_q;
  assign cfg_ext   = {25'd0, window_len_i};

  always_comb begin
    state_d = state_q; v_d = v_q; bv_d = bv_q; lv_d = lv_q; lo_d = lo_q;
    slot_d = slot_q; bs_d = bs_q; ls_d = ls_q; us_d = us_q; oldest_d = oldest_q;
    sel_d = sel_q; moved_d = moved_q; swap2_d = swap2_q; valid_d = valid_q;
    pos_d = pos_q; best_d = best_q; first_d = first_q; idx_d = idx_q;
    lc_d = lc_q; uc_d = uc_q; wlen_d = wlen_q; res_d = res_q;
    med_d = med_q; medv_d = medv_q; out_valid_d = out_valid_q;
    val_we = 1'b0; val_waddr = slot_q; val_wdata = v_q; val_raddr = '0;
    inl_we = 1'b0; inl_waddr = slot_q; inl_wdata = sel_q; inl_raddr = oldest_q;
    pos_we = 1'b0; pos_waddr = slot_q; pos_wdata = pos_q; pos_raddr = oldest_q;
    heap_we = 1'b0; heap_waddr = {sel_q, pos_q}; heap_wdata = slot_q; heap_raddr = '0;

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          v_d = sample_i;
          state_d = S_START;
        end
      end
      S_START: begin
        if (total < wlen_q) begin
          valid_d = (total + LW'(1) == wlen_q);
          moved_d = 1'b0;
          swap2_d = 1'b0;
          if (total == '0) begin
            val_we = 1'b1; val_waddr = '0;
            inl_we = 1'b1; inl_waddr = '0; inl_wdata = 1'b1;
            heap_we = 1'b1; heap_waddr = {SelLower, HPW'(0)}; heap_wdata = '0;
            pos_we = 1'b1; pos_waddr = '0; pos_wdata = '0;
            lc_d = CW'(1);
            state_d = S_RES0;
          end else begin
            slot_d = SW'(total);
            sel_d = !(lc_q > uc_q);
            pos_d = HPW'(sel_d ? lc_q : uc_q);
            val_we = 1'b1; val_waddr = slot_d;
            inl_we = 1'b1; inl_waddr = slot_d; inl_wdata = sel_d;
            heap_we = 1'b1; heap_waddr = {sel_d, pos_d}; heap_wdata = slot_d;
            pos_we = 1'b1; pos_waddr = slot_d; pos_wdata = pos_d;
            if (sel_d) lc_d = lc_q + CW'(1);
            else uc_d = uc_q + CW'(1);
            state_d = S_SETTLE;
          end
        end else begin
          valid_d = 1'b1;
          moved_d = 1'b0;
          swap2_d = 1'b0;
          slot_d = oldest_q;
          state_d = S_OLDD;
        end
      end
      S_OLDD: begin
        sel_d = inl_rdata;
        pos_d = pos_rdata;
        val_we = 1'b1;
        oldest_d = (LW'(oldest_q) + LW'(1) >= wlen_q) ? '0 : oldest_q + SW'(1);
        state_d = S_SETTLE;
      end
      S_SETTLE: state_d = (pos_q == '0) ? S_CHK : S_UP;
      S_UP: begin
        if (pos_q == '0) begin
          heap_we = 1'b1; pos_we = 1'b1;
          state_d = S_UPEND;
        end else begin
          heap_raddr = {sel_q, parent};
          state_d = S_UPH;
        end
      end
      S_UPH: begin
        bs_d = heap_rdata;
        val_raddr = heap_rdata;
        state_d = S_UPV;
      end
      S_UPV: begin
        heap_we = 1'b1; pos_we = 1'b1;
        if (ahead(sel_q, v_q, val_rdata)) begin
          heap_wdata = bs_q; pos_waddr = bs_q;
          pos_d = parent;
          moved_d = 1'b1;
          state_d = S_UP;
        end else begin
          state_d = S_UPEND;
        end
      end
      S_UPEND: state_d = moved_q ? S_CHK : S_DN;
      S_CHK: begin
        if (other_cnt != '0) begin
          heap_raddr = {!sel_q, HPW'(0)};
          state_d = S_CHH;
        end else begin
          state_d = moved_q ? S_RES0 : S_DN;
        end
      end
      S_CHH: begin
        val_raddr = heap_rdata;
        state_d = S_CHV;
      end
      S_CHV: begin
        if (ahead(sel_q, v_q, val_rdata)) state_d = S_SW0;
        else state_d = moved_q ? S_RES0 : S_DN;
      end
      S_SW0: begin
        heap_raddr = {SelLower, HPW'(0)};
        state_d = S_SW1;
      end
      S_SW1: begin
        ls_d = heap_rdata;
        heap_raddr = {SelUpper, HPW'(0)};
        val_raddr = heap_rdata;
        state_d = S_SW2;
      end
      S_SW2: begin
        us_d = heap_rdata;
        lv_d = val_rdata;
        val_raddr = heap_rdata;
        state_d = S_SW3;
      end
      S_SW3: begin
        v_d = val_rdata;
        inl_we = 1'b1; inl_waddr = ls_q; inl_wdata = 1'b0;
        heap_we = 1'b1; heap_waddr = {SelLower, HPW'(0)}; heap_wdata = us_q;
        pos_we = 1'b1; pos_waddr = us_q; pos_wdata = '0;
        state_d = S_SW4;
      end
      S_SW4: begin
        inl_we = 1'b1; inl_waddr = us_q; inl_wdata = 1'b1;
        heap_we = 1'b1; heap_waddr = {SelUpper, HPW'(0)}; heap_wdata = ls_q;
        pos_we = 1'b1; pos_waddr = ls_q; pos_wdata = '0;
        sel_d = SelLower; pos_d = '0; slot_d = us_q; swap2_d = 1'b1;
        state_d = S_DN;
      end
      S_DN: begin
        if (first_w >= cnt_w) begin
          heap_we = 1'b1; pos_we = 1'b1;
          state_d = S_DNEND;
        end else begin
          first_d = first_w;
          idx_d = last_w - FW'(1);
          best_d = pos_q;
          bv_d = v_q;
          heap_raddr = {sel_q, HPW'(idx_d)};
          state_d = S_DCH;
        end
      end
      S_DCH: begin
        val_raddr = heap_rdata;
        state_d = S_DCV;
      end
      S_DCV: begin
        if (ahead(sel_q, val_rdata, bv_q)) begin
          best_d = HPW'(idx_q);
          bv_d = val_rdata;
          bs_d = cand_q;
        end
        if (idx_q == first_q) begin
          state_d = S_DSEL;
        end else begin
          idx_d = idx_q - FW'(1);
          heap_raddr = {sel_q, HPW'(idx_d)};
          state_d = S_DCH;
        end
      end
      S_DSEL: begin
        heap_we = 1'b1; pos_we = 1'b1;
        if (best_q == pos_q) begin
          state_d = S_DNEND;
        end else begin
          heap_wdata = bs_q; pos_waddr = bs_q;
          pos_d = best_q;
          state_d = S_DN;
        end
      end
      S_DNEND: begin
        if (swap2_q) begin
          sel_d = SelUpper; pos_d = '0; slot_d = ls_q; v_d = lv_q; swap2_d = 1'b0;
          state_d = S_DN;
        end else begin
          state_d = S_RES0;
        end
      end
      S_RES0: begin
        if (!valid_q) begin
          res_d = '0;
          state_d = S_OUT;
        end else begin
          heap_raddr = {SelLower, HPW'(0)};
          state_d = S_RES1;
        end
      end
      S_RES1: begin
        val_raddr = heap_rdata;
        state_d = S_RES2;
      end
      S_RES2: begin
        lo_d = val_rdata;
        if (wlen_q[0]) begin
          res_d = {val_rdata[SB-1], val_rdata} + {val_rdata[SB-1], val_rdata};
          state_d = S_OUT;
        end else begin
          heap_raddr = {SelUpper, HPW'(0)};
          state_d = S_RES3;
        end
      end
      S_RES3: begin
        val_raddr = heap_rdata;
        state_d = S_RES4;
      end
      S_RES4: begin
        res_d = {lo_q[SB-1], lo_q} + {val_rdata[SB-1], val_rdata};
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          med_d = res_q;
          medv_d = valid_q;
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (window_len_we_i) begin
      if (cfg_ext < 32'd2) wlen_d = LW'(2);
      else if (cfg_ext > 32'(WINDOW_MAX)) wlen_d = LW'(WINDOW_MAX);
      else wlen_d = LW'(cfg_ext);
      lc_d = '0;
      uc_d = '0;
      oldest_d = '0;
    end
  end

  assign cand_we = (state_q == S_DCH);
  assign cand_d  = heap_rdata;

  always_ff @(posedge clk_i) begin
    if (cand_we) cand_q <= cand_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      lc_q        <= '0;
      uc_q        <= '0;
      oldest_q    <= '0;
      wlen_q      <= LW'(WinReset);
      out_valid_q <= 1'b0;
      moved_q     <= 1'b0;
      swap2_q     <= 1'b0;
      valid_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      lc_q        <= lc_d;
      uc_q        <= uc_d;
      oldest_q    <= oldest_d;
      wlen_q      <= wlen_d;
      out_valid_q <= out_valid_d;
      moved_q     <= moved_d;
      swap2_q     <= swap2_d;
      valid_q     <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d; bv_q <= bv_d; lv_q <= lv_d; lo_q <= lo_d;
    slot_q <= slot_d; bs_q <= bs_d; ls_q <= ls_d; us_q <= us_d;
    sel_q <= sel_d; pos_q <= pos_d; best_q <= best_d;
    first_q <= first_d; idx_q <= idx_d; res_q <= res_d;
    med_q <= med_d; medv_q <= medv_d;
  end

  assign in_ready_o       = (state_q == S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign median_doubled_o = med_q;
  assign median_valid_o   = medv_q;

  a_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lc_q == uc_q) || (lc_q == uc_q + CW'(1)))
    else $error("heap sizes out of balance");
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (LW'(lc_q) + LW'(uc_q)) <= wlen_q)
    else $error("window overfilled");
  a_oldest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    LW'(oldest_q) < wlen_q)
    else $error("oldest slot beyond window");
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_START))
    else $error("accepted transaction not started");

endmodule

[src/mmdh_ram.sv]
`timescale 1ns / 1ps
module mmdh_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[tb/tb_moving_median_double_heap_unit.sv]
`timescale 1ns / 1ps
module tb_moving_median_double_heap_unit;
  import mmdh_pkg::*;

  localparam int unsigned WinMax = 64;
  localparam int unsigned Arity = 8;
  localparam int unsigned CycleLimit = 2_000_000;

  typedef struct packed {
    logic signed [16:0] med2;
    logic               vld;
  } median_t;

  // Running-median predictor plus the queue of medians still owed by the block.
  class median_board;
    logic signed [15:0] slot_val[WinMax];
    bit                 slot_lo[WinMax];
    int unsigned        slot_pos[WinMax];
    int unsigned        lo_heap[WinMax/2];
    int unsigned        hi_heap[WinMax/2];
    int unsigned        lo_cnt, hi_cnt, oldest, win;
    median_t            owed[$];
    int unsigned        n_bad, n_seen, n_valid;

    function new();
      win = 8;
      lo_cnt = 0; hi_cnt = 0; oldest = 0;
      n_bad = 0; n_seen = 0; n_valid = 0;
    endfunction

    function void set_window(logic [6:0] w);
      win = (w < 2) ? 2 : (w > WinMax) ? WinMax : w;
      lo_cnt = 0; hi_cnt = 0; oldest = 0;
    endfunction

    function bit ahead(bit is_max, logic signed [15:0] a, logic signed [15:0] b);
      return is_max ? (a > b) : (a < b);
    endfunction

    function int unsigned heap_at(bit sel, int unsigned i);
      return (sel == SelLower) ? lo_heap[i] : hi_heap[i];
    endfunction

    function void place(bit sel, int unsigned p, int unsigned s);
      if (sel == SelLower) lo_heap[p] = s;
      else hi_heap[p] = s;
      slot_pos[s] = p;
    endfunction

    function void sift_up(bit sel, int unsigned p, int unsigned s);
      int unsigned par, ps;
      while (p > 0) begin
        par = (p - 1) / Arity;
        ps = heap_at(sel, par);
        if (!ahead(sel, slot_val[s], slot_val[ps])) break;
        place(sel, p, ps);
        p = par;
      end
      place(sel, p, s);
    endfunction

    function void sift_down(bit sel, int unsigned cnt, int unsigned p, int unsigned s);
      int unsigned first, last, best;
      logic signed [15:0] bv;
      forever begin
        first = Arity * p + 1;
        best = p;
        bv = slot_val[s];
        if (first < cnt) begin
          last = first + Arity;
          if (last > cnt) last = cnt;
          // walk from the highest position so ties go to it
          for (int unsigned i = last; i > first; i--) begin
            if (ahead(sel, slot_val[heap_at(sel, i - 1)], bv)) begin
              best = i - 1;
              bv = slot_val[heap_at(sel, i - 1)];
            end
          end
        end
        if (best == p) break;
        place(sel, p, heap_at(sel, best));
        p = best;
      end
      place(sel, p, s);
    endfunction

    function void swap_heads();
      int unsigned ls, us;
      ls = lo_heap[0];
      us = hi_heap[0];
      slot_lo[ls] = 1'b0;
      slot_lo[us] = 1'b1;
      place(SelLower, 0, us);
      place(SelUpper, 0, ls);
      sift_down(SelLower, lo_cnt, 0, us);
      sift_down(SelUpper, hi_cnt, 0, ls);
    endfunction

    function void settle(int unsigned s, logic signed [15:0] v);
      bit sel;
      int unsigned cnt, oc, p;
      sel = slot_lo[s];
      cnt = sel ? lo_cnt : hi_cnt;
      oc = sel ? hi_cnt : lo_cnt;
      p = slot_pos[s];
      slot_val[s] = v;
      if (p > 0 && ahead(sel, v, slot_val[heap_at(sel, (p - 1) / Arity)])) begin
        sift_up(sel, p, s);
        if (oc > 0 && ahead(sel, v, slot_val[heap_at(!sel, 0)])) swap_heads();
      end else if (p == 0 && oc > 0 && ahead(sel, v, slot_val[heap_at(!sel, 0)])) begin
        swap_heads();
      end else begin
        sift_down(sel, cnt, p, s);
      end
    endfunction

    function void note_sample(logic signed [15:0] v);
      int unsigned total;
      bit vld;
      median_t m;
      total = lo_cnt + hi_cnt;
      if (total < win) begin
        if (total == 0) begin
          slot_val[0] = v;
          slot_lo[0] = 1'b1;
          place(SelLower, 0, 0);
          lo_cnt = 1;
        end else if (lo_cnt > hi_cnt) begin
          slot_lo[total] = 1'b0;
          place(SelUpper, hi_cnt, total);
          hi_cnt++;
          settle(total, v);
        end else begin
          slot_lo[total] = 1'b1;
          place(SelLower, lo_cnt, total);
          lo_cnt++;
          settle(total, v);
        end
        vld = (total + 1 == win);
      end else begin
        settle(oldest, v);
        oldest = (oldest + 1 >= win) ? 0 : oldest + 1;
        vld = 1'b1;
      end
      m.vld = vld;
      m.med2 = '0;
      if (vld) begin
        if (win % 2 == 1) m.med2 = 17'(slot_val[lo_heap[0]]) * 2;
        else m.med2 = 17'(slot_val[lo_heap[0]]) + 17'(slot_val[hi_heap[0]]);
      end
      owed.push_back(m);
    endfunction

    task check_result(logic signed [16:0] med2, logic vld);
      median_t e;
      n_seen++;
      if (owed.size() == 0) begin
        report_bad($sformatf("unexpected result med2=%0d valid=%0b", med2, vld));
        return;
      end
      e = owed.pop_front();
      if (vld) n_valid++;
      if (vld !== e.vld)
        report_bad($sformatf("median_valid %0b, want %0b", vld, e.vld));
      if (med2 !== e.med2)
        report_bad($sformatf("median_doubled %0d, want %0d", med2, e.med2));
    endtask

    task report_bad(string msg);
      n_bad++;
      $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               window_len_we_i = 1'b0;
  logic [6:0]         window_len_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [15:0] sample_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [16:0] median_doubled_o;
  logic               median_valid_o;

  median_board board = new();
  int unsigned cycles = 0;
  int unsigned n_sent = 0;
  int unsigned burst_left = 0;
  bit          hold_req = 1'b0;
  string       windows_seen = "8";

  always #1 clk_i = ~clk_i;

  moving_median_double_heap_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .window_len_we_i (window_len_we_i),
    .window_len_i    (window_len_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .sample_i        (sample_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .median_doubled_o(median_doubled_o),
    .median_valid_o  (median_valid_o)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) board.check_result(median_doubled_o, median_valid_o);
  end

  // receiver: changes stall mode now and then, with a long hold-off on request
  initial begin
    int unsigned mode_left, mode, hold_left;
    mode_left = 0; mode = 0; hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = 400;
        hold_req = 1'b0;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 300);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i = 1'b0;
      end else begin
        case (mode)
          0: out_ready_i = 1'b1;
          1: out_ready_i = ($urandom_range(0, 1) == 1);
          2: out_ready_i = (cycles % 4 == 0);
          default: out_ready_i = ($urandom_range(0, 9) == 0);
        endcase
      end
    end
  end

  // one transaction; valid stays up across a burst
  task automatic send_sample(logic signed [15:0] v, bit bursty);
    int unsigned gap;
    if (bursty && burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 40) : $urandom_range(0, 3);
      if (gap > 0) begin
        in_valid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 30);
    end
    if (burst_left > 0) burst_left--;
    in_valid_i = 1'b1;
    sample_i = v;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_sample(v);
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (board.owed.size() > 0) @(posedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  task automatic write_window(logic [6:0] w);
    drain();
    window_len_i = w;
    window_len_we_i = 1'b1;
    board.set_window(w);
    @(negedge clk_i);
    window_len_we_i = 1'b0;
    windows_seen = {windows_seen, $sformatf(" %0d", w)};
  endtask

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 3) - 2);
      1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      2: return 16'($urandom_range(0, 40) - 20);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [6:0] wins[12];
    int unsigned n;
    wins = '{7'd0, 7'd64, 7'd3, 7'd127, 7'd1, 7'd65, 7'd2, 7'd5, 7'd16, 7'd33, 7'd9, 7'd4};
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed at reset window of 8: extremes, ties, monotone runs
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh0000, 1'b0);
    send_sample(-16'sd1, 1'b0);
    for (int i = 0; i < 6; i++) send_sample(16'sd5, 1'b0);
    for (int i = 0; i < 7; i++) send_sample(16'(i * 1000 - 3000), 1'b0);
    for (int i = 0; i < 7; i++) send_sample(16'(3000 - i * 1111), 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh7fff, 1'b0);

    for (int ph = 0; ph < 12; ph++) begin
      write_window(wins[ph]);
      if (ph == 3) hold_req = 1'b1;
      n = (ph == 1 || ph == 3 || ph == 5) ? 110 : 60;
      for (int i = 0; i < n; i++) send_sample(pick_sample(), 1'b1);
    end
    drain();
    repeat (100) @(negedge clk_i);
    $display("sent %0d samples, checked %0d results (%0d with a full window)",
             n_sent, board.n_seen, board.n_valid);
    $display("window lengths written: %s", windows_seen);
    if (board.n_bad == 0 && board.owed.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d results missing", board.n_bad, board.owed.size());
      $display("status: fail");
    end
    $finish;
  end
endmodule
